// ===== hw/rtl/tfc_pkg.sv =====
// Shared types and constants for the tunnel fragment classifier.
// Holds the request and result payload structs and the route, version and hop codes.
// No dependencies; every other file of the block refers to this package.
package tfc_pkg;

    // Bit positions inside the metadata and route words.
    localparam int LEN_MSB   = 15;
    localparam int L2_LSB    = 20;
    localparam int L2_MSB    = 26;
    localparam int V4_BIT    = 27;
    localparam int V6_BIT    = 28;
    localparam int HOP_LSB   = 28;
    localparam int HOP_MSB   = 30;

    localparam logic [2:0] HOP_FRAGMENT   = 3'd1;
    localparam logic [2:0] HOP_REASSEMBLE = 3'd2;

    localparam logic [2:0] ROUTE_FRAGMENT   = 3'd0;
    localparam logic [2:0] ROUTE_REASSEMBLE = 3'd1;
    localparam logic [2:0] ROUTE_UDF_LOW    = 3'd2;
    localparam logic [2:0] ROUTE_UDF_MID    = 3'd3;
    localparam logic [2:0] ROUTE_UDF_HIGH   = 3'd4;

    localparam logic [7:0] UDF_LOW_MIN  = 8'd1;
    localparam logic [7:0] UDF_LOW_MAX  = 8'd40;
    localparam logic [7:0] UDF_MID_MIN  = 8'd41;
    localparam logic [7:0] UDF_MID_MAX  = 8'd56;
    localparam logic [7:0] UDF_HIGH_MIN = 8'd65;
    localparam logic [7:0] UDF_HIGH_MAX = 8'd68;

    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_IPV4    = 2'd1;
    localparam logic [1:0] VER_IPV6    = 2'd2;

    localparam logic [5:0] V4_HDR_LEN   = 6'd20;
    localparam logic [5:0] V6_HDR_LEN   = 6'd40;
    localparam logic [3:0] V6_FRAG_LEN  = 4'd8;
    localparam logic [6:0] ALIGN_BYTES  = 7'd8;

    typedef struct packed {
        logic [31:0] metadata_word;
        logic [31:0] hop_word;
        logic [15:0] mtu_value;
        logic [7:0]  user_field;
        logic [15:0] buffer_extent;
    } tfc_desc_t;

    typedef struct packed {
        logic        classify_ok;
        logic [2:0]  route_code;
        logic [1:0]  ver_code;
        logic        version_ambiguous;
        logic        fragment_ok;
        logic [5:0]  net_hdr_len;
        logic [3:0]  extension_header_length;
        logic [15:0] orig_payload_len;
        logic [15:0] first_payload_length;
        logic [15:0] frag1_wire_len;
        logic [15:0] frag2_payload_len;
        logic [15:0] frag2_wire_len;
    } tfc_result_t;

    // Classification handed from the route picker to the layout unit.
    typedef struct packed {
        logic        ok;
        logic [2:0]  route_code;
        logic [1:0]  ver_code;
        logic        ambiguous;
        logic [6:0]  l2_offset;
        logic [15:0] pkt_len;
    } tfc_class_t;

endpackage

// ===== hw/rtl/tfc_if.sv =====
// Handshake channel interfaces for the tunnel fragment classifier.
// Depends on tfc_pkg for the request and result payload structs.
interface tfc_desc_if;
    logic                  valid;
    logic                  ready;
    tfc_pkg::tfc_desc_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfc_result_if;
    logic                  valid;
    logic                  ready;
    tfc_pkg::tfc_result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tunnel_fragment_classifier_unit.sv =====
// Top level of the tunnel fragment classifier: input register, classify and layout
// logic, result register. Depends on tfc_pkg, tfc_if, tfc_classify and tfc_layout.
//
// Usage:
//   desc   - request channel carrying one packet descriptor (metadata word, route
//            word, MTU, user field, buffer extent). A request is taken at a rising
//            edge where valid and ready are both high.
//   result - one result per request, in request order, same handshake.
//   The input register feeds the result register through the classify and layout
//   arithmetic, and result.valid comes from the result register. Throughput is one
//   request per cycle while result.ready stays high; the two registers form a
//   two-stage pipeline whose stages each advance when the stage after them is
//   empty or being emptied.
//   When the receiver holds result.ready low, the result register holds its
//   value, the input register fills behind it, and desc.ready then drops until
//   the result is taken. No request is lost or repeated.
//   Reset (rst_n low, asynchronous) empties both stages; there is no other
//   state and no configuration.
module tunnel_fragment_classifier_unit #(
    parameter int MIN_DESCRIPTOR_LENGTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tfc_desc_if.sink             desc,
    tfc_result_if.source         result
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    tfc_pkg::tfc_desc_t    in_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tfc_pkg::tfc_result_t  out_data_reg;

    tfc_pkg::tfc_class_t   cls;
    tfc_pkg::tfc_result_t  res;
    logic                  out_load;
    logic                  in_load;

    tfc_classify #(
        .MIN_DESCRIPTOR_LENGTH (MIN_DESCRIPTOR_LENGTH)
    ) u_classify (
        .desc (in_data_reg),
        .cls  (cls)
    );

    tfc_layout u_layout (
        .cls (cls),
        .mtu (in_data_reg.mtu_value),
        .res (res)
    );

    assign out_load   = in_valid_reg && (!out_valid_reg || result.ready);
    assign desc.ready = !in_valid_reg || out_load;
    assign in_load    = desc.valid && desc.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= desc.data;
        end
        if (out_load)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // A fragment layout is only ever reported on a classified fragment route.
    a_frag_needs_route: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.fragment_ok |->
            result.data.classify_ok
            && (result.data.route_code == tfc_pkg::ROUTE_FRAGMENT))
        else $error("fragment layout reported without a fragment route");

    // The layout splits the payload on an 8-byte boundary with nothing lost.
    a_split_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.fragment_ok |->
            (result.data.first_payload_length[2:0] == 3'b000)
            && (16'(result.data.first_payload_length
                    + result.data.frag2_payload_len)
                == result.data.orig_payload_len))
        else $error("fragment payload split is inconsistent");

    // A rejected descriptor carries no route or version information.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.classify_ok |->
            (result.data.route_code == tfc_pkg::ROUTE_FRAGMENT)
            && (result.data.ver_code == tfc_pkg::VER_UNKNOWN)
            && !result.data.version_ambiguous && !result.data.fragment_ok)
        else $error("rejected descriptor has nonzero result fields");

    // A held input stage keeps its request until the result stage frees up.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage dropped a pending request");

endmodule

// ===== hw/rtl/tfc_classify.sv =====
// Descriptor check and route selection for the tunnel fragment classifier.
// Depends on tfc_pkg for field positions, codes and the classification struct.
module tfc_classify #(
    parameter int MIN_DESCRIPTOR_LENGTH = 16
) (
    input  tfc_pkg::tfc_desc_t   desc,
    output tfc_pkg::tfc_class_t  cls
);

    logic [15:0] plen;
    logic [2:0]  hop;
    logic        v4;
    logic        v6;
    logic        length_ok;
    logic        route_found;
    logic [2:0]  code;

    assign plen = desc.metadata_word[tfc_pkg::LEN_MSB:0];
    assign hop  = desc.hop_word[tfc_pkg::HOP_MSB:tfc_pkg::HOP_LSB];
    assign v4   = desc.metadata_word[tfc_pkg::V4_BIT];
    assign v6   = desc.metadata_word[tfc_pkg::V6_BIT];

    assign length_ok = (desc.buffer_extent >= 16'(MIN_DESCRIPTOR_LENGTH))
                    && (plen >= 16'(MIN_DESCRIPTOR_LENGTH))
                    && (plen <= desc.buffer_extent);

    // Hop flags take priority over the user-field ranges.
    always_comb
    begin
        route_found = 1'b1;
        code        = tfc_pkg::ROUTE_FRAGMENT;
        if (hop == tfc_pkg::HOP_FRAGMENT)
        begin
            code = tfc_pkg::ROUTE_FRAGMENT;
        end
        else if (hop == tfc_pkg::HOP_REASSEMBLE)
        begin
            code = tfc_pkg::ROUTE_REASSEMBLE;
        end
        else if (desc.user_field inside {[tfc_pkg::UDF_LOW_MIN:tfc_pkg::UDF_LOW_MAX]})
        begin
            code = tfc_pkg::ROUTE_UDF_LOW;
        end
        else if (desc.user_field inside {[tfc_pkg::UDF_MID_MIN:tfc_pkg::UDF_MID_MAX]})
        begin
            code = tfc_pkg::ROUTE_UDF_MID;
        end
        else if (desc.user_field inside {[tfc_pkg::UDF_HIGH_MIN:tfc_pkg::UDF_HIGH_MAX]})
        begin
            code = tfc_pkg::ROUTE_UDF_HIGH;
        end
        else
        begin
            route_found = 1'b0;
        end
    end

    always_comb
    begin
        cls.ok            = length_ok && route_found;
        cls.route_code    = code;
        cls.ambiguous     = (v4 == v6);
        cls.l2_offset     = desc.metadata_word[tfc_pkg::L2_MSB:tfc_pkg::L2_LSB];
        cls.pkt_len       = plen;
        if (v4 && !v6)
        begin
            cls.ver_code = tfc_pkg::VER_IPV4;
        end
        else if (v6 && !v4)
        begin
            cls.ver_code = tfc_pkg::VER_IPV6;
        end
        else
        begin
            cls.ver_code = tfc_pkg::VER_UNKNOWN;
        end
    end

endmodule

// ===== hw/rtl/tfc_layout.sv =====
// Two-fragment layout arithmetic and final result assembly.
// Depends on tfc_pkg for header sizes, codes and the payload structs.
module tfc_layout (
    input  tfc_pkg::tfc_class_t   cls,
    input  logic [15:0]           mtu,
    output tfc_pkg::tfc_result_t  res
);

    logic [5:0]  nh;
    logic [3:0]  eh;
    logic [6:0]  hdr_total;
    logic [7:0]  l2_nh;
    logic [7:0]  prefix;
    logic [16:0] l2_mtu;
    logic [15:0] orig;
    logic [15:0] room;
    logic [15:0] cap;
    logic [15:0] second;
    logic [16:0] w1;
    logic [16:0] w2;
    logic        plan_ok;
    logic        layout_ok;

    always_comb
    begin
        if (cls.ver_code == tfc_pkg::VER_IPV6)
        begin
            nh = tfc_pkg::V6_HDR_LEN;
            eh = tfc_pkg::V6_FRAG_LEN;
        end
        else
        begin
            nh = tfc_pkg::V4_HDR_LEN;
            eh = 4'd0;
        end
    end

    assign hdr_total = 7'(nh) + 7'(eh);
    assign l2_nh     = 8'(cls.l2_offset) + 8'(nh);
    assign prefix    = 8'(cls.l2_offset) + 8'(hdr_total);
    assign l2_mtu    = 17'(cls.l2_offset) + 17'(mtu);

    // Differences may wrap when the plan is rejected; the result is masked then.
    assign orig   = cls.pkt_len - 16'(l2_nh);
    assign room   = mtu - 16'(hdr_total);
    assign cap    = {room[15:3], 3'b000};
    assign second = orig - cap;
    assign w1     = 17'(prefix) + 17'(cap);
    assign w2     = 17'(prefix) + 17'(second);

    assign plan_ok = cls.ok
                  && (cls.route_code == tfc_pkg::ROUTE_FRAGMENT)
                  && (l2_mtu < 17'(cls.pkt_len))
                  && !cls.ambiguous
                  && (cls.ver_code != tfc_pkg::VER_UNKNOWN)
                  && (mtu >= 16'(hdr_total) + 16'(tfc_pkg::ALIGN_BYTES))
                  && (cls.pkt_len > 16'(l2_nh));

    assign layout_ok = plan_ok
                    && (cap != 16'd0)
                    && (cap < orig)
                    && !w1[16]
                    && !w2[16];

    always_comb
    begin
        res = '0;
        if (cls.ok)
        begin
            res.classify_ok       = 1'b1;
            res.route_code        = cls.route_code;
            res.ver_code          = cls.ver_code;
            res.version_ambiguous = cls.ambiguous;
        end
        if (layout_ok)
        begin
            res.fragment_ok             = 1'b1;
            res.net_hdr_len             = nh;
            res.extension_header_length = eh;
            res.orig_payload_len        = orig;
            res.first_payload_length    = cap;
            res.frag1_wire_len          = w1[15:0];
            res.frag2_payload_len       = second;
            res.frag2_wire_len          = w2[15:0];
        end
    end

endmodule

// ===== tb/tunnel_fragment_classifier_unit_tb.sv =====
// Self-checking testbench for tunnel_fragment_classifier_unit: a directed table, then random
// descriptors under varying backpressure, each result checked against a local layout predictor.
// Depends on tfc_pkg, tfc_if and the RTL of the block.
module tunnel_fragment_classifier_unit_tb;

    localparam int MIN_LEN      = 16;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 610;

    // Hop codes that select no route on their own.
    localparam logic [2:0] HOP_NONE   = 3'd0;
    localparam logic [2:0] HOP_SPARE  = 3'd4;
    localparam logic [2:0] HOP_UNUSED = 3'd7;

    typedef struct {
        tfc_pkg::tfc_desc_t   desc;
        bit                   typed;
        tfc_pkg::tfc_result_t result;
    } table_row_t;

    logic clk;
    logic rst_n;

    tfc_desc_if   desc_ch();
    tfc_result_if result_ch();

    tunnel_fragment_classifier_unit #(
        .MIN_DESCRIPTOR_LENGTH(MIN_LEN)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .desc   (desc_ch),
        .result (result_ch)
    );

    tfc_pkg::tfc_result_t awaited_results[$];
    tfc_pkg::tfc_result_t next_result;
    table_row_t           directed_rows[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int mismatches;
    int requests_sent;
    int results_checked;
    int layouts_checked;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // Two-fragment layout predictor for one packet descriptor.
    function automatic tfc_pkg::tfc_result_t classify_fragment(tfc_pkg::tfc_desc_t d);
        tfc_pkg::tfc_result_t r;
        int unsigned plen;
        int unsigned l2;
        int unsigned mtu;
        int unsigned nh;
        int unsigned eh;
        int unsigned orig;
        int unsigned cap;
        int unsigned second;
        int unsigned w1;
        int unsigned w2;
        logic [2:0]  hop;
        logic [2:0]  route;
        logic [7:0]  udf;
        logic        v4;
        logic        v6;
        r    = '0;
        plen = d.metadata_word[tfc_pkg::LEN_MSB:0];
        mtu  = d.mtu_value;
        udf  = d.user_field;
        if (d.buffer_extent < MIN_LEN || plen < MIN_LEN || plen > d.buffer_extent)
            return r;
        l2  = d.metadata_word[tfc_pkg::L2_MSB:tfc_pkg::L2_LSB];
        hop = d.hop_word[tfc_pkg::HOP_MSB:tfc_pkg::HOP_LSB];
        v4  = d.metadata_word[tfc_pkg::V4_BIT];
        v6  = d.metadata_word[tfc_pkg::V6_BIT];
        // Hop flags win over the user field.
        if (hop == tfc_pkg::HOP_FRAGMENT)
            route = tfc_pkg::ROUTE_FRAGMENT;
        else if (hop == tfc_pkg::HOP_REASSEMBLE)
            route = tfc_pkg::ROUTE_REASSEMBLE;
        else if (udf >= tfc_pkg::UDF_LOW_MIN && udf <= tfc_pkg::UDF_LOW_MAX)
            route = tfc_pkg::ROUTE_UDF_LOW;
        else if (udf >= tfc_pkg::UDF_MID_MIN && udf <= tfc_pkg::UDF_MID_MAX)
            route = tfc_pkg::ROUTE_UDF_MID;
        else if (udf >= tfc_pkg::UDF_HIGH_MIN && udf <= tfc_pkg::UDF_HIGH_MAX)
            route = tfc_pkg::ROUTE_UDF_HIGH;
        else
            return r;
        r.classify_ok       = 1'b1;
        r.route_code        = route;
        r.version_ambiguous = (v4 == v6);
        if (v4 && !v6)
            r.ver_code = tfc_pkg::VER_IPV4;
        else if (v6 && !v4)
            r.ver_code = tfc_pkg::VER_IPV6;
        else
            r.ver_code = tfc_pkg::VER_UNKNOWN;
        if (route != tfc_pkg::ROUTE_FRAGMENT)
            return r;
        if (l2 + mtu >= plen || r.version_ambiguous || r.ver_code == tfc_pkg::VER_UNKNOWN)
            return r;
        if (r.ver_code == tfc_pkg::VER_IPV4)
        begin
            nh = tfc_pkg::V4_HDR_LEN;
            eh = 0;
        end
        else
        begin
            nh = tfc_pkg::V6_HDR_LEN;
            eh = tfc_pkg::V6_FRAG_LEN;
        end
        if (mtu < nh + eh + tfc_pkg::ALIGN_BYTES || plen <= l2 + nh)
            return r;
        orig = plen - l2 - nh;
        cap  = (mtu - nh - eh) & ~(int'(tfc_pkg::ALIGN_BYTES) - 1);
        if (cap == 0 || cap >= orig)
            return r;
        second = orig - cap;
        w1     = l2 + nh + eh + cap;
        w2     = l2 + nh + eh + second;
        if (orig > 65535 || cap > 65535 || second > 65535 || w1 > 65535 || w2 > 65535)
            return r;
        r.fragment_ok             = 1'b1;
        r.net_hdr_len             = 6'(nh);
        r.extension_header_length = 4'(eh);
        r.orig_payload_len        = 16'(orig);
        r.first_payload_length    = 16'(cap);
        r.frag1_wire_len          = 16'(w1);
        r.frag2_payload_len       = 16'(second);
        r.frag2_wire_len          = 16'(w2);
        return r;
    endfunction

    function automatic logic [31:0] meta_of(int plen, int l2, bit v4, bit v6);
        logic [31:0] m;
        m = '0;
        m[tfc_pkg::LEN_MSB:0]             = 16'(plen);
        m[tfc_pkg::L2_MSB:tfc_pkg::L2_LSB] = 7'(l2);
        m[tfc_pkg::V4_BIT]                = v4;
        m[tfc_pkg::V6_BIT]                = v6;
        return m;
    endfunction

    function automatic logic [31:0] route_of(logic [2:0] hop);
        logic [31:0] w;
        w = '0;
        w[tfc_pkg::HOP_MSB:tfc_pkg::HOP_LSB] = hop;
        return w;
    endfunction

    function automatic tfc_pkg::tfc_desc_t mk_desc(logic [31:0] meta, logic [31:0] rword,
                                                   logic [15:0] mtu, logic [7:0] udf,
                                                   logic [15:0] extent);
        tfc_pkg::tfc_desc_t d;
        d.metadata_word = meta;
        d.hop_word      = rword;
        d.mtu_value     = mtu;
        d.user_field    = udf;
        d.buffer_extent = extent;
        return d;
    endfunction

    function automatic tfc_pkg::tfc_result_t mk_result(bit ok, logic [2:0] route,
                                                       logic [1:0] ver, bit amb);
        tfc_pkg::tfc_result_t r;
        r                   = '0;
        r.classify_ok       = ok;
        r.route_code        = route;
        r.ver_code          = ver;
        r.version_ambiguous = amb;
        return r;
    endfunction

    task automatic add_typed(tfc_pkg::tfc_desc_t d, tfc_pkg::tfc_result_t r);
        table_row_t row;
        row.desc   = d;
        row.typed  = 1'b1;
        row.result = r;
        directed_rows.push_back(row);
    endtask

    task automatic add_predicted(tfc_pkg::tfc_desc_t d);
        table_row_t row;
        row.desc   = d;
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed_table();
        tfc_pkg::tfc_result_t none;
        none = '0;
        add_typed(mk_desc(32'h0, 32'h0, 0, 0, 0), none);
        add_typed(mk_desc(32'hffff_ffff, 32'hffff_ffff, 65535, 255, 65535), none);
        // Length checks: short extent, short packet, packet longer than the buffer.
        add_typed(mk_desc(meta_of(15, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 8, 0, 15),
                  none);
        add_typed(mk_desc(meta_of(15, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 8, 0, 100),
                  none);
        add_typed(mk_desc(meta_of(101, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 8, 0, 100),
                  none);
        // Route selection over the hop flags and the user-field ranges.
        add_typed(mk_desc(meta_of(16, 0, 1, 0), route_of(tfc_pkg::HOP_REASSEMBLE), 0, 0, 16),
                  mk_result(1, tfc_pkg::ROUTE_REASSEMBLE, tfc_pkg::VER_IPV4, 0));
        add_typed(mk_desc(meta_of(64, 3, 0, 1), route_of(HOP_NONE), 0, 1, 65535),
                  mk_result(1, tfc_pkg::ROUTE_UDF_LOW, tfc_pkg::VER_IPV6, 0));
        add_typed(mk_desc(meta_of(64, 3, 0, 0), route_of(HOP_NONE), 0, 40, 65535),
                  mk_result(1, tfc_pkg::ROUTE_UDF_LOW, tfc_pkg::VER_UNKNOWN, 1));
        add_typed(mk_desc(meta_of(64, 3, 1, 1), route_of(HOP_NONE), 0, 41, 65535),
                  mk_result(1, tfc_pkg::ROUTE_UDF_MID, tfc_pkg::VER_UNKNOWN, 1));
        add_typed(mk_desc(meta_of(64, 3, 1, 0), route_of(HOP_UNUSED), 0, 56, 65535),
                  mk_result(1, tfc_pkg::ROUTE_UDF_MID, tfc_pkg::VER_IPV4, 0));
        add_typed(mk_desc(meta_of(64, 3, 1, 0), route_of(HOP_NONE), 0, 57, 65535), none);
        add_typed(mk_desc(meta_of(64, 3, 1, 0), route_of(HOP_UNUSED), 0, 65, 65535),
                  mk_result(1, tfc_pkg::ROUTE_UDF_HIGH, tfc_pkg::VER_IPV4, 0));
        add_typed(mk_desc(meta_of(64, 3, 0, 1), route_of(HOP_SPARE), 0, 68, 65535),
                  mk_result(1, tfc_pkg::ROUTE_UDF_HIGH, tfc_pkg::VER_IPV6, 0));
        add_typed(mk_desc(meta_of(64, 3, 0, 1), route_of(HOP_NONE), 0, 69, 65535), none);
        add_typed(mk_desc(meta_of(64, 3, 0, 1), route_of(tfc_pkg::HOP_REASSEMBLE), 0, 200,
                          65535),
                  mk_result(1, tfc_pkg::ROUTE_REASSEMBLE, tfc_pkg::VER_IPV6, 0));
        // Fragment plans that are rejected after the route is chosen.
        add_typed(mk_desc(meta_of(1000, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 1000, 0,
                          1000),
                  mk_result(1, tfc_pkg::ROUTE_FRAGMENT, tfc_pkg::VER_IPV4, 0));
        add_typed(mk_desc(meta_of(1000, 0, 1, 1), route_of(tfc_pkg::HOP_FRAGMENT), 500, 0,
                          1000),
                  mk_result(1, tfc_pkg::ROUTE_FRAGMENT, tfc_pkg::VER_UNKNOWN, 1));
        add_typed(mk_desc(meta_of(1000, 0, 0, 0), route_of(tfc_pkg::HOP_FRAGMENT), 500, 0,
                          1000),
                  mk_result(1, tfc_pkg::ROUTE_FRAGMENT, tfc_pkg::VER_UNKNOWN, 1));
        add_typed(mk_desc(meta_of(1000, 0, 0, 1), route_of(tfc_pkg::HOP_FRAGMENT), 55, 0,
                          1000),
                  mk_result(1, tfc_pkg::ROUTE_FRAGMENT, tfc_pkg::VER_IPV6, 0));
        add_typed(mk_desc(meta_of(1000, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 27, 0,
                          1000),
                  mk_result(1, tfc_pkg::ROUTE_FRAGMENT, tfc_pkg::VER_IPV4, 0));
        // Accepted layouts, including the smallest MTU and the longest packet.
        add_predicted(mk_desc(meta_of(1500, 14, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 576,
                              30, 2000));
        add_predicted(mk_desc(meta_of(1500, 0, 0, 1), route_of(tfc_pkg::HOP_FRAGMENT), 1280,
                              0, 1500));
        add_predicted(mk_desc(meta_of(1000, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT), 28,
                              0, 1000));
        add_predicted(mk_desc(meta_of(200, 127, 0, 1), route_of(tfc_pkg::HOP_FRAGMENT), 56,
                              0, 200));
        add_predicted(mk_desc(meta_of(65535, 127, 0, 1), route_of(tfc_pkg::HOP_FRAGMENT),
                              65407, 0, 65535));
        add_predicted(mk_desc(meta_of(65535, 0, 1, 0), route_of(tfc_pkg::HOP_FRAGMENT),
                              65534, 255, 65535));
    endtask

    function automatic tfc_pkg::tfc_desc_t random_desc();
        tfc_pkg::tfc_desc_t d;
        int                 kind;
        int                 plen;
        int                 room;
        d.metadata_word = $urandom;
        d.hop_word      = $urandom;
        d.mtu_value     = 16'($urandom_range(0, 65535));
        d.user_field    = 8'($urandom_range(0, 255));
        d.buffer_extent = 16'($urandom_range(0, 65535));
        kind            = $urandom_range(0, 99);
        if (kind < 85)
        begin
            plen = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_LEN, 65535)
                                               : $urandom_range(MIN_LEN, 3000);
            d.metadata_word[tfc_pkg::LEN_MSB:0] = 16'(plen);
            d.buffer_extent = ($urandom_range(0, 3) == 0) ? 16'(plen)
                                                          : 16'($urandom_range(plen, 65535));
        end
        if (kind < 60)
        begin
            // Well-formed fragment request with random layout content.
            d.hop_word[tfc_pkg::HOP_MSB:tfc_pkg::HOP_LSB] = tfc_pkg::HOP_FRAGMENT;
            if ($urandom_range(0, 9) != 0)
            begin
                d.metadata_word[tfc_pkg::V4_BIT] = 1'($urandom_range(0, 1));
                d.metadata_word[tfc_pkg::V6_BIT] = !d.metadata_word[tfc_pkg::V4_BIT];
            end
            room = plen - int'(d.metadata_word[tfc_pkg::L2_MSB:tfc_pkg::L2_LSB]);
            if (room > 1 && $urandom_range(0, 7) != 0)
                d.mtu_value = 16'($urandom_range(0, room - 1));
        end
        else if (kind < 85 && $urandom_range(0, 1) == 0)
        begin
            // Lean on the edges of the user-field ranges.
            case ($urandom_range(0, 9))
                0: d.user_field = 8'd0;
                1: d.user_field = tfc_pkg::UDF_LOW_MIN;
                2: d.user_field = tfc_pkg::UDF_LOW_MAX;
                3: d.user_field = tfc_pkg::UDF_MID_MIN;
                4: d.user_field = tfc_pkg::UDF_MID_MAX;
                5: d.user_field = tfc_pkg::UDF_MID_MAX + 8'd1;
                6: d.user_field = tfc_pkg::UDF_HIGH_MIN - 8'd1;
                7: d.user_field = tfc_pkg::UDF_HIGH_MIN;
                8: d.user_field = tfc_pkg::UDF_HIGH_MAX;
                default: d.user_field = tfc_pkg::UDF_HIGH_MAX + 8'd1;
            endcase
        end
        return d;
    endfunction

    // Offers one request from a falling edge and returns at the falling edge after it is taken.
    task automatic send_desc(input tfc_pkg::tfc_desc_t d, input tfc_pkg::tfc_result_t golden);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            desc_ch.valid = 1'b0;
            @(negedge clk);
        end
        desc_ch.data  = d;
        desc_ch.valid = 1'b1;
        next_result   = golden;
        @(posedge clk);
        while (!desc_ch.ready)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        desc_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(int count, int tx_pct, int rx_pct, int hold_at);
        tfc_pkg::tfc_desc_t d;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                desc_ch.valid = 1'b0;
                @(posedge clk);
                hold_requests++;
                @(negedge clk);
            end
            d = random_desc();
            send_desc(d, classify_fragment(d));
        end
    endtask

    task automatic cmp_field(string name, logic [15:0] golden, logic [15:0] got);
        if (golden !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, golden, got);
            mismatches++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen       = 0;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready = 1'b0;
            end
            else
                result_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        tfc_pkg::tfc_result_t golden;
        tfc_pkg::tfc_result_t got;
        if (rst_n)
        begin
            if (desc_ch.valid && desc_ch.ready)
                awaited_results.push_back(next_result);
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    golden = awaited_results.pop_front();
                    results_checked++;
                    if (golden.fragment_ok)
                        layouts_checked++;
                    cmp_field("classify_ok", golden.classify_ok, got.classify_ok);
                    cmp_field("route_code", golden.route_code, got.route_code);
                    cmp_field("ver_code", golden.ver_code, got.ver_code);
                    cmp_field("version_ambiguous", golden.version_ambiguous,
                              got.version_ambiguous);
                    cmp_field("fragment_ok", golden.fragment_ok, got.fragment_ok);
                    cmp_field("net_hdr_len", golden.net_hdr_len, got.net_hdr_len);
                    cmp_field("extension_header_length", golden.extension_header_length,
                              got.extension_header_length);
                    cmp_field("orig_payload_len", golden.orig_payload_len,
                              got.orig_payload_len);
                    cmp_field("first_payload_length", golden.first_payload_length,
                              got.first_payload_length);
                    cmp_field("frag1_wire_len", golden.frag1_wire_len, got.frag1_wire_len);
                    cmp_field("frag2_payload_len", golden.frag2_payload_len,
                              got.frag2_payload_len);
                    cmp_field("frag2_wire_len", golden.frag2_wire_len, got.frag2_wire_len);
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        desc_ch.valid   = 1'b0;
        desc_ch.data    = '0;
        next_result     = '0;
        tx_idle_pct     = 22;
        rx_idle_pct     = 62;
        hold_requests   = 0;
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        layouts_checked = 0;
        build_directed_table();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_desc(directed_rows[i].desc,
                      directed_rows[i].typed ? directed_rows[i].result
                                             : classify_fragment(directed_rows[i].desc));
        end

        run_random(PHASE_ITEMS, 22, 62, -1);
        wait_drained();
        run_random(PHASE_ITEMS, 62, 22, -1);
        wait_drained();
        // No idling here; the long receiver hold-off backs the pipeline up to the sender.
        run_random(PHASE_ITEMS, 0, 0, 100);
        wait_drained();

        $display("Sent %0d descriptor requests and checked %0d results, %0d of them with a",
                 requests_sent, results_checked, layouts_checked);
        $display("two-fragment layout, under three backpressure mixes and one long stall.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
